// ----- hw/rtl/ptps_pkg.sv -----
`default_nettype none

package ptps_pkg;

	// Store geometry and pixel depth defaults
	localparam int STORE_BYTES_DEF    = 65536;
	localparam int MAX_PIXEL_BITS_DEF = 32;

	// Byte and accumulator sizes: a pixel spans at most five bytes
	localparam int BYTE_W    = 8;
	localparam int ACC_BYTES = 5;
	localparam int ACC_W     = ACC_BYTES * BYTE_W;
	localparam int SPAN_W    = 3;

	// Divider lane: 17-bit dividend covers canvas_height + tile_size - 1
	localparam int DIV_W   = 17;
	localparam int DEN_W   = 8;
	localparam int DCNT_W  = 5;
	localparam int DIV_LANES = 3;

	// Register reset values
	localparam logic [15:0] CANVAS_W_RST = 16'd296;
	localparam logic [15:0] CANVAS_H_RST = 16'd128;
	localparam logic [5:0]  BPP_RST      = 6'd1;
	localparam logic [7:0]  TILE_RST     = 8'd32;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BPP    = 2'd2,
		CFG_TILE   = 2'd3
	} cfg_idx_t;

	// One restoring-division lane: quotient shifts in at the bottom of num
	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] rem;
	} div_lane_t;

	function automatic div_lane_t div_step(input div_lane_t lane, input logic [DEN_W-1:0] den);
		div_lane_t        res;
		logic [DEN_W:0]   r;
		logic             qb;
		r  = {lane.rem, lane.num[DIV_W-1]};
		qb = (r >= {1'b0, den});
		if (qb) begin
			r = r - {1'b0, den};
		end
		res.num = {lane.num[DIV_W-2:0], qb};
		res.rem = r[DEN_W-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/packed_tiled_pixel_store_core.sv -----
// Flow: an in-canvas item runs the tile-size divider, the multiply states, address and
// store-bound check, then gathers its span (1..5 bytes); a read returns it, a write merges and writes it back.
// Throughput: one item at a time; the 17-step tile-size divider and the single byte-wide
// memory port (one byte read or written per cycle) bound it. Off-canvas items skip both.
// Reset: async, active low; a clearing pass then zeroes every byte of the store with
// s_tready low; configuration writes are taken during it.
`default_nettype none

module packed_tiled_pixel_store_core #(
	parameter int STORE_BYTES    = ptps_pkg::STORE_BYTES_DEF,
	parameter int MAX_PIXEL_BITS = ptps_pkg::MAX_PIXEL_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // pixel_column[15:0], pixel_row[31:16], write_value[63:32]
	input  wire logic [0:0]  s_tuser,   // opcode
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // read_value[31:0]
	output logic [0:0]       m_tuser    // out_of_range
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int SW = AW + 1;
	localparam int PW = 2 * AW + 2;
	localparam int BW = ptps_pkg::BYTE_W;
	localparam int AC = ptps_pkg::ACC_W;
	localparam logic [SW-1:0] SAT_V    = {1'b1, {AW{1'b0}}};
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
		ST_ADDR, ST_CHK, ST_RD, ST_MOD, ST_WR, ST_RES
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] cw_q, ch_q;
	logic [5:0]  bpp_q;
	logic [7:0]  ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q  <= ptps_pkg::CANVAS_W_RST;
			ch_q  <= ptps_pkg::CANVAS_H_RST;
			bpp_q <= ptps_pkg::BPP_RST;
			ts_q  <= ptps_pkg::TILE_RST;
		end else if (cfg_we) begin
			unique case (ptps_pkg::cfg_idx_t'(cfg_index))
				ptps_pkg::CFG_WIDTH:  cw_q  <= cfg_data;
				ptps_pkg::CFG_HEIGHT: ch_q  <= cfg_data;
				ptps_pkg::CFG_BPP:    bpp_q <= cfg_data[5:0];
				ptps_pkg::CFG_TILE:   ts_q  <= cfg_data[7:0];
			endcase
		end
	end

	// Effective tile size and depth
	logic [7:0]  ts_eff;
	logic [5:0]  depth;
	logic [31:0] mask32;
	logic [AC-1:0] mask40;

	assign ts_eff = (ts_q == 8'd0) ? 8'd1 : ts_q;
	assign depth  = (bpp_q == 6'd0) ? 6'd1 :
	                (bpp_q > 6'(MAX_PIXEL_BITS)) ? 6'(MAX_PIXEL_BITS) : bpp_q;
	assign mask32 = 32'hFFFF_FFFF >> (6'd32 - depth);
	assign mask40 = AC'(mask32);

	// Datapath registers
	logic                    op_q;
	logic [31:0]             val_q;
	ptps_pkg::div_lane_t     lane_q [ptps_pkg::DIV_LANES];
	logic [15:0]             tsq_q, lin_q;
	logic [31:0]             tdx_q;
	logic [20:0]             slotbits_q, bitoff_q;
	logic [32:0]             tidx_q;
	logic [SW-1:0]           sa_q, sb_q;
	logic [PW-1:0]           prod_q, addr_q;
	logic [2:0]              bit_q;
	logic [ptps_pkg::SPAN_W-1:0] span_q;
	logic [AC-1:0]           acc_q;

	// Control registers
	logic [ptps_pkg::DCNT_W-1:0] dcnt_q;
	logic [AW-1:0]               clr_q;
	logic [ptps_pkg::SPAN_W-1:0] iss_q;
	logic                        rv_s1;
	logic [ptps_pkg::SPAN_W-1:0] rb_s1;
	logic                        oor_q;
	logic                        out_valid_q;

	// Handshake and canvas check
	logic in_fire, canvas_oor;
	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign canvas_oor = (s_tdata[15:0] >= cw_q) || (s_tdata[31:16] >= ch_q);

	// Result register takes a new transaction once it is empty or being drained
	logic res_load;
	assign res_load = (state_q == ST_RES) && (!out_valid_q || m_tready);

	// Pixel extraction and merge
	logic [AC-1:0] acc_shr, acc_new;
	logic [31:0]   rd_val;
	logic [21:0]   slot_bytes;
	logic [PW-1:0] end_addr;
	logic [AW-1:0] base;

	assign acc_shr    = acc_q >> bit_q;
	assign rd_val     = acc_shr[31:0] & mask32;
	assign acc_new    = (acc_q & ~(mask40 << bit_q)) | ((AC'(val_q) & mask40) << bit_q);
	assign slot_bytes = (22'(slotbits_q) + 22'd7) >> 3;
	assign end_addr   = addr_q + PW'(span_q);
	assign base       = addr_q[AW-1:0];

	// Memory port control
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [BW-1:0] wr_data, mem_rdata_q;

	assign rd_en   = (state_q == ST_RD) && (iss_q < span_q);
	assign rd_addr = base + AW'(iss_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base + AW'(iss_q);
		wr_data = acc_q[{iss_q, 3'b000} +: BW];
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_WR) begin
			wr_en = 1'b1;
		end
	end

	// Byte store
	logic [BW-1:0] mem [STORE_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rdata_q <= mem[rd_addr];
		end
	end

	// Datapath: division lanes, address arithmetic, gather and merge
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					op_q          <= s_tuser[0];
					val_q         <= s_tdata[63:32];
					lane_q[0].num <= 17'(s_tdata[15:0]);
					lane_q[1].num <= 17'(s_tdata[31:16]);
					lane_q[2].num <= 17'(ch_q) + 17'(ts_eff) - 17'd1;
					lane_q[0].rem <= '0;
					lane_q[1].rem <= '0;
					lane_q[2].rem <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < ptps_pkg::DIV_LANES; i++) begin
					lane_q[i] <= ptps_pkg::div_step(lane_q[i], ts_eff);
				end
			end
			ST_MUL1: begin
				tsq_q <= 16'(ts_eff) * 16'(ts_eff);
				lin_q <= 16'(lane_q[0].rem) * 16'(ts_eff) + 16'(lane_q[1].rem);
				tdx_q <= 32'(lane_q[0].num[15:0]) * 32'(lane_q[2].num[15:0]);
			end
			ST_MUL2: begin
				slotbits_q <= 21'(tsq_q) * 21'(depth);
				bitoff_q   <= 21'(lin_q) * 21'(depth);
				tidx_q     <= 33'(tdx_q) + 33'(lane_q[1].num[15:0]);
			end
			ST_MUL3: begin
				// saturate both factors: a saturated nonzero product already lies past the store
				sa_q <= ((tidx_q >> AW) != '0) ? SAT_V : SW'(tidx_q);
				sb_q <= ((slot_bytes >> AW) != '0) ? SAT_V : SW'(slot_bytes);
			end
			ST_MUL4: begin
				prod_q <= PW'(sa_q) * PW'(sb_q);
			end
			ST_ADDR: begin
				addr_q <= prod_q + PW'(bitoff_q >> 3);
				bit_q  <= bitoff_q[2:0];
				span_q <= 3'((7'(bitoff_q[2:0]) + 7'(depth) + 7'd7) >> 3);
			end
			ST_CHK: begin
				acc_q <= '0;
			end
			ST_RD: begin
				if (rv_s1) begin
					acc_q[{rb_s1, 3'b000} +: BW] <= mem_rdata_q;
				end
			end
			ST_MOD: begin
				acc_q <= acc_new;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			dcnt_q      <= '0;
			iss_q       <= '0;
			rv_s1       <= 1'b0;
			rb_s1       <= '0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= '0;
		end else begin
			rv_s1 <= rd_en;
			rb_s1 <= iss_q;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						oor_q  <= canvas_oor;
						dcnt_q <= '0;
						if (!canvas_oor) begin
							state_q <= ST_DIV;
						end else if (s_tuser[0]) begin
							state_q <= ST_RES;
						end
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(ptps_pkg::DIV_W - 1)) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_MUL4;
				ST_MUL4: state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_CHK;
				ST_CHK: begin
					iss_q <= '0;
					if (end_addr > PW'(STORE_BYTES)) begin
						oor_q   <= 1'b1;
						state_q <= op_q ? ST_RES : ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (rd_en) begin
						iss_q <= iss_q + 3'd1;
					end
					if (rv_s1 && (rb_s1 == span_q - 3'd1)) begin
						state_q <= op_q ? ST_RES : ST_MOD;
					end
				end
				ST_MOD: begin
					iss_q   <= '0;
					state_q <= ST_WR;
				end
				ST_WR: begin
					iss_q <= iss_q + 3'd1;
					if (iss_q == span_q - 3'd1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RES: begin
					if (res_load) begin
						m_tdata <= oor_q ? 32'd0 : rd_val;
						m_tuser <= oor_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	// store writes stay inside the memory
	a_wr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < 32'(STORE_BYTES)))
		else $error("byte write beyond store");

	// one item at a time: the port never reads and writes in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("read and write overlap on the byte store");

	// a new result appears only out of the result state
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RES))
		else $error("result raised outside result state");

	// out-of-range results carry zero data
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("out-of-range result with nonzero data");

	// gather and scatter work on one to five bytes
	a_span_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (span_q >= 3'd1 && span_q <= 3'd5))
		else $error("byte span out of bounds");
`endif

endmodule

`default_nettype wire
